### design/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg - shared types and constants of the sorted member table
// Holds the table geometry, field widths, request and status codes and the
// layout of one stored entry.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W   = 48;
  localparam int HB_W    = 63;
  localparam int TIME_W  = 32;
  localparam int IDX_W   = 8;
  localparam int OCNT_W  = 9;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  // width used to compare a request index against the entry count
  localparam int IDX_CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 152;

  // tdata bit positions
  localparam int KEY_LSB  = 0;
  localparam int HB_LSB   = KEY_LSB + KEY_W;
  localparam int TIME_LSB = HB_LSB + HB_W;
  localparam int IDX_LSB  = TIME_LSB + TIME_W;
  localparam int OCNT_LSB = TIME_LSB + TIME_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_LOOKUP = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_RANGE     = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PUT,
    ST_RDIDX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HB_W-1:0]   hb;
    logic [TIME_W-1:0] tm;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // result of the shared key comparator
  typedef struct packed {
    logic lt;   // request key below stored key
    logic eq;   // request key equals stored key
  } cmp_res_t;

endpackage

### design/smt_ram.sv
// ----------------------------------------------------------------------------
// smt_ram - generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/smt_cmp.sv
// ----------------------------------------------------------------------------
// smt_cmp - shared key comparator
// Compares the request key with one stored key per cycle for the sorted
// position search and the match search.
// ----------------------------------------------------------------------------
module smt_cmp (
  input  logic [smt_pkg::KEY_W-1:0] req_key,
  input  logic [smt_pkg::KEY_W-1:0] mem_key,
  output smt_pkg::cmp_res_t         res
);

  always_comb begin
    res.lt = (req_key < mem_key);
    res.eq = (req_key == mem_key);
  end

endmodule

### design/sorted_member_table.sv
// ----------------------------------------------------------------------------
// sorted_member_table - membership table sorted by ascending member key
// A sequencer walks one table memory with a single key comparator: scan for
// the position or match, then shift entries one per cycle on insert / erase.
// ----------------------------------------------------------------------------
// with n live entries: lookup, update, erase and insert scan up to n stored keys;
//   insert and erase then shift the later entries by one slot
// both are bounded by the single read and single write port of the table memory
// one request in flight; the next is taken once the result sits in the output register
// reset (synchronous, active low) empties the table and drops any result;
//   memory contents are not cleared
module sorted_member_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // member_key, heartbeat_value, heartbeat_time, entry_index, one zero pad bit
  input  logic [smt_pkg::IN_DATA_W-1:0]    in_tdata,
  // command
  input  logic [smt_pkg::CMD_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // found_key, found_heartbeat, found_time, entry_count
  output logic [smt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status
  output logic [smt_pkg::STAT_W-1:0]       out_tuser
);

  // control state
  smt_pkg::state_t              state_r, state_nxt;
  logic [smt_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [smt_pkg::CNT_W-1:0]    issue_r, issue_nxt;    // next scan address
  logic [smt_pkg::CNT_W-1:0]    sh_r, sh_nxt;          // shift read cursor
  logic [smt_pkg::CNT_W-1:0]    pos_r, pos_nxt;        // found position
  logic                         pend_r, pend_nxt;      // read data due this cycle
  logic [smt_pkg::ADDR_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // request and result payload
  smt_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [smt_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [smt_pkg::HB_W-1:0]     hb_r, hb_nxt;
  logic [smt_pkg::TIME_W-1:0]   tm_r, tm_nxt;
  logic [smt_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  smt_pkg::stat_t               res_stat_r, res_stat_nxt;
  smt_pkg::entry_t              res_ent_r, res_ent_nxt;
  logic [smt_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [smt_pkg::STAT_W-1:0]   out_user_r, out_user_nxt;

  // memory port
  logic                         mem_we;
  logic [smt_pkg::ADDR_W-1:0]   mem_waddr;
  smt_pkg::entry_t              mem_wdata;
  logic [smt_pkg::ADDR_W-1:0]   mem_raddr;
  logic [smt_pkg::ENTRY_W-1:0]  mem_rdata;
  smt_pkg::entry_t              rd_ent;

  smt_pkg::cmp_res_t            cmp;
  logic                         hit;
  logic                         in_fire;
  logic                         is_insert;

  assign rd_ent    = smt_pkg::entry_t'(mem_rdata);
  assign in_tready = (state_r == smt_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign is_insert = (cmd_r == smt_pkg::CMD_INSERT);

  // insert stops at the first larger key, the others at the first equal key
  assign hit = pend_r && (is_insert ? cmp.lt : cmp.eq);

  smt_ram #(
    .WIDTH (smt_pkg::ENTRY_W),
    .DEPTH (smt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  smt_cmp u_cmp (
    .req_key (key_r),
    .mem_key (rd_ent.key),
    .res     (cmp)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    sh_nxt        = sh_r;
    pos_nxt       = pos_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    hb_nxt        = hb_r;
    tm_nxt        = tm_r;
    idx_nxt       = idx_r;
    res_stat_nxt  = res_stat_r;
    res_ent_nxt   = res_ent_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = rd_ent;
    mem_raddr     = '0;

    // result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      smt_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt      = smt_pkg::cmd_t'(in_tuser);
          key_nxt      = in_tdata[smt_pkg::KEY_LSB +: smt_pkg::KEY_W];
          hb_nxt       = in_tdata[smt_pkg::HB_LSB +: smt_pkg::HB_W];
          tm_nxt       = in_tdata[smt_pkg::TIME_LSB +: smt_pkg::TIME_W];
          idx_nxt      = in_tdata[smt_pkg::IDX_LSB +: smt_pkg::IDX_W];
          res_stat_nxt = smt_pkg::STAT_OK;
          res_ent_nxt  = '0;
          issue_nxt    = '0;
          case (smt_pkg::cmd_t'(in_tuser))
            smt_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              state_nxt = smt_pkg::ST_DONE;
            end
            smt_pkg::CMD_INSERT: begin
              if (count_r >= smt_pkg::CNT_W'(smt_pkg::TABLE_DEPTH)) begin
                res_stat_nxt = smt_pkg::STAT_FULL;
                state_nxt    = smt_pkg::ST_DONE;
              end else begin
                state_nxt = smt_pkg::ST_SCAN;
              end
            end
            smt_pkg::CMD_ERASE, smt_pkg::CMD_UPDATE, smt_pkg::CMD_LOOKUP: begin
              state_nxt = smt_pkg::ST_SCAN;
            end
            smt_pkg::CMD_READ: begin
              state_nxt = smt_pkg::ST_RDIDX;
            end
            default: begin
              state_nxt = smt_pkg::ST_DONE;
            end
          endcase
        end
      end

      // one stored key compared per cycle, reads issued one ahead
      smt_pkg::ST_SCAN: begin
        if (hit || (!pend_r && issue_r >= count_r)) begin
          pos_nxt = hit ? smt_pkg::CNT_W'(pend_idx_r) : count_r;
          case (cmd_r)
            smt_pkg::CMD_INSERT: begin
              sh_nxt    = count_r;
              state_nxt = smt_pkg::ST_SHIFT;
            end
            smt_pkg::CMD_ERASE: begin
              if (hit) begin
                sh_nxt    = smt_pkg::CNT_W'(pend_idx_r) + smt_pkg::CNT_W'(1);
                state_nxt = smt_pkg::ST_SHIFT;
              end else begin
                res_stat_nxt = smt_pkg::STAT_NOT_FOUND;
                state_nxt    = smt_pkg::ST_DONE;
              end
            end
            smt_pkg::CMD_UPDATE: begin
              if (hit) begin
                state_nxt = smt_pkg::ST_PUT;
              end else begin
                res_stat_nxt = smt_pkg::STAT_NOT_FOUND;
                state_nxt    = smt_pkg::ST_DONE;
              end
            end
            default: begin
              // lookup
              if (hit) begin
                res_ent_nxt.hb = rd_ent.hb;
              end else begin
                res_stat_nxt = smt_pkg::STAT_NOT_FOUND;
              end
              state_nxt = smt_pkg::ST_DONE;
            end
          endcase
        end else if (issue_r < count_r) begin
          mem_raddr    = smt_pkg::ADDR_W'(issue_r);
          pend_nxt     = 1'b1;
          pend_idx_nxt = smt_pkg::ADDR_W'(issue_r);
          issue_nxt    = issue_r + smt_pkg::CNT_W'(1);
        end
      end

      // move one entry per cycle: read one slot, write it back a slot over
      smt_pkg::ST_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_wdata = rd_ent;
          mem_waddr = is_insert ? smt_pkg::ADDR_W'(pend_idx_r + smt_pkg::ADDR_W'(1))
                                : smt_pkg::ADDR_W'(pend_idx_r - smt_pkg::ADDR_W'(1));
        end
        if (is_insert && sh_r > pos_r) begin
          mem_raddr    = smt_pkg::ADDR_W'(sh_r - smt_pkg::CNT_W'(1));
          pend_nxt     = 1'b1;
          pend_idx_nxt = smt_pkg::ADDR_W'(sh_r - smt_pkg::CNT_W'(1));
          sh_nxt       = sh_r - smt_pkg::CNT_W'(1);
        end else if (!is_insert && sh_r < count_r) begin
          mem_raddr    = smt_pkg::ADDR_W'(sh_r);
          pend_nxt     = 1'b1;
          pend_idx_nxt = smt_pkg::ADDR_W'(sh_r);
          sh_nxt       = sh_r + smt_pkg::CNT_W'(1);
        end else if (!pend_r) begin
          if (is_insert) begin
            state_nxt = smt_pkg::ST_PUT;
          end else begin
            count_nxt = count_r - smt_pkg::CNT_W'(1);
            state_nxt = smt_pkg::ST_DONE;
          end
        end
      end

      // new entry on insert, new heartbeat and time on update
      smt_pkg::ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = smt_pkg::ADDR_W'(pos_r);
        mem_wdata = '{key: key_r, hb: hb_r, tm: tm_r};
        if (is_insert) begin
          count_nxt = count_r + smt_pkg::CNT_W'(1);
        end
        state_nxt = smt_pkg::ST_DONE;
      end

      smt_pkg::ST_RDIDX: begin
        if (pend_r) begin
          res_ent_nxt = rd_ent;
          state_nxt   = smt_pkg::ST_DONE;
        end else if (smt_pkg::IDX_CMP_W'(idx_r) >= smt_pkg::IDX_CMP_W'(count_r)) begin
          res_stat_nxt = smt_pkg::STAT_RANGE;
          state_nxt    = smt_pkg::ST_DONE;
        end else begin
          mem_raddr = smt_pkg::ADDR_W'(idx_r);
          pend_nxt  = 1'b1;
        end
      end

      // load the output register once it is free
      smt_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_stat_r;
          out_data_nxt  = {smt_pkg::OCNT_W'(count_r), res_ent_r.tm, res_ent_r.hb,
                           res_ent_r.key};
          state_nxt     = smt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = smt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smt_pkg::ST_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      sh_r        <= '0;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      sh_r        <= sh_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    hb_r       <= hb_nxt;
    tm_r       <= tm_nxt;
    idx_r      <= idx_nxt;
    res_stat_r <= res_stat_nxt;
    res_ent_r  <= res_ent_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### design/smt_chk.sv
// ----------------------------------------------------------------------------
// smt_chk - port-level checker for the sorted member table
// Watches the request and result streams and is bound to the top level.
// ----------------------------------------------------------------------------
module smt_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [smt_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [smt_pkg::CMD_W-1:0]      in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [smt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [smt_pkg::STAT_W-1:0]     out_tuser
);

  logic [smt_pkg::OCNT_W-1:0] out_cnt;
  assign out_cnt = out_tdata[smt_pkg::OCNT_LSB +: smt_pkg::OCNT_W];

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed under stall");

  // full status only with a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == smt_pkg::STAT_FULL |->
      out_cnt == smt_pkg::OCNT_W'(smt_pkg::TABLE_DEPTH))
    else $error("full status with table not full");

  // failed requests return no entry data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != smt_pkg::STAT_OK |->
      out_tdata[smt_pkg::OCNT_LSB-1:0] == '0)
    else $error("entry data on failed request");

  // a result only follows a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tready && !in_tvalid |=> !out_tvalid)
    else $error("result without request");

endmodule

bind sorted_member_table smt_chk u_smt_chk (.*);
